/* design/ccrde_pkg.sv */
// Shared types and constants for the character-cell rectangle draw engine.
// No dependencies; used by ccrde_ctrl, ccrde_dp and the top level.
package ccrde_pkg;

  localparam int CFG_WIDTH_W  = 8;
  localparam int CFG_HEIGHT_W = 7;
  localparam int CFG_DATA_W   = 8;
  localparam int CFG_IDX_W    = 1;
  localparam int COORD_W      = 12;
  localparam int GLYPH_W      = 8;
  localparam int ATTR_W       = 16;
  localparam int CELL_W       = GLYPH_W + ATTR_W;
  localparam int PROD_W       = CFG_WIDTH_W + CFG_HEIGHT_W;

  localparam int DEF_MAX_WIDTH  = 128;
  localparam int DEF_MAX_HEIGHT = 64;

  localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RESET  = 8'd80;
  localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RESET = 7'd25;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

  // request types
  localparam logic REQ_DRAW = 1'b0;
  localparam logic REQ_READ = 1'b1;

  localparam logic STATUS_DONE = 1'b0;
  localparam logic STATUS_OOR  = 1'b1;

  typedef struct packed {
    logic                      req_type;
    logic signed [COORD_W-1:0] first_x;
    logic signed [COORD_W-1:0] first_y;
    logic signed [COORD_W-1:0] second_x;
    logic signed [COORD_W-1:0] second_y;
    logic [GLYPH_W-1:0]        glyph;
    logic [ATTR_W-1:0]         attr;
    logic                      filled;
  } req_t;

  typedef struct packed {
    logic [GLYPH_W-1:0] read_glyph;
    logic [ATTR_W-1:0]  read_attr;
    logic               status;
  } rsp_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_CLEAR,
    OP_SORT,
    OP_CLIP,
    OP_BASE,
    OP_STEP,
    OP_RADDR,
    OP_RREAD
  } op_t;

  typedef struct packed {
    op_t  op;
    logic rsp_load;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic empty;
    logic walk_last;
  } stat_t;

endpackage

/* design/ccrde_ctrl.sv */
// Controller state machine of the rectangle draw engine.
// Sequences clear, draw and read operations; drives ccrde_dp through cmd_t.
// Depends on ccrde_pkg.
module ccrde_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  input  logic             req_read,
  output logic             req_stall,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  input  ccrde_pkg::stat_t stat,
  output ccrde_pkg::cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SORT,
    S_CLIP,
    S_BASE,
    S_WALK,
    S_RADDR,
    S_RREAD,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;

  assign req_stall = (state != S_IDLE);

  always_comb begin
    state_next   = state;
    cmd.op       = ccrde_pkg::OP_NONE;
    cmd.rsp_load = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.op = ccrde_pkg::OP_CLEAR;
        if (stat.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid) begin
          cmd.op     = ccrde_pkg::OP_LOAD;
          state_next = req_read ? S_RADDR : S_SORT;
        end
      end
      S_SORT: begin
        cmd.op     = ccrde_pkg::OP_SORT;
        state_next = S_CLIP;
      end
      S_CLIP: begin
        cmd.op     = ccrde_pkg::OP_CLIP;
        state_next = S_BASE;
      end
      S_BASE: begin
        cmd.op     = ccrde_pkg::OP_BASE;
        state_next = stat.empty ? S_DONE : S_WALK;
      end
      S_WALK: begin
        cmd.op = ccrde_pkg::OP_STEP;
        if (stat.walk_last) state_next = S_DONE;
      end
      S_RADDR: begin
        cmd.op     = ccrde_pkg::OP_RADDR;
        state_next = S_RREAD;
      end
      S_RREAD: begin
        cmd.op     = ccrde_pkg::OP_RREAD;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!rsp_valid || !rsp_stall) begin
          cmd.rsp_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.rsp_load) rsp_valid <= 1'b1;
      else if (!rsp_stall) rsp_valid <= 1'b0;
    end
  end

  a_rsp_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == S_DONE))
    else $error("response raised outside completion");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |-> !cmd.rsp_load)
    else $error("stalled response overwritten");

  a_clear_after_reset: assert property (@(posedge clk)
    rst |=> req_stall)
    else $error("request taken before clearing pass");

  a_walk_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK && stat.walk_last) |=> state == S_DONE)
    else $error("walk did not finish on last cell");

endmodule

/* design/ccrde_dp.sv */
// Datapath of the rectangle draw engine: config registers, corner sort and
// clip, cell walker, cell memory and response register. Depends on ccrde_pkg.
module ccrde_dp #(
  parameter int MAX_WIDTH  = ccrde_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = ccrde_pkg::DEF_MAX_HEIGHT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  ccrde_pkg::cmd_t                      cmd,
  output ccrde_pkg::stat_t                     stat,
  input  ccrde_pkg::req_t                      req,
  output ccrde_pkg::rsp_t                      rsp,
  input  logic                                 cfg_we,
  input  logic [ccrde_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ccrde_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int WW     = ccrde_pkg::CFG_WIDTH_W;
  localparam int HW     = ccrde_pkg::CFG_HEIGHT_W;
  localparam int XW     = ccrde_pkg::COORD_W + 1;
  localparam int PW     = ccrde_pkg::PROD_W;
  localparam int CW     = ccrde_pkg::CELL_W;
  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int W_REG_MAX = (1 << WW) - 1;
  localparam int H_REG_MAX = (1 << HW) - 1;
  localparam int W_CAP_I   = (MAX_WIDTH < W_REG_MAX) ? MAX_WIDTH : W_REG_MAX;
  localparam int H_CAP_I   = (MAX_HEIGHT < H_REG_MAX) ? MAX_HEIGHT : H_REG_MAX;
  localparam logic [WW-1:0] W_CAP = WW'(W_CAP_I);
  localparam logic [HW-1:0] H_CAP = HW'(H_CAP_I);
  localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(DEPTH - 1);

  logic [WW-1:0] width_in_use;
  logic [HW-1:0] height_in_use;
  logic [WW-1:0] eff_w;
  logic [HW-1:0] eff_h;

  ccrde_pkg::req_t req_q;
  ccrde_pkg::rsp_t rsp_next;

  logic signed [XW-1:0] x0, x1, y0, y1;
  logic signed [XW-1:0] lx_c, ly_c, hx_c, hy_c, ww_s, hh_s;
  logic [WW-1:0] lx, last_x, col;
  logic [HW-1:0] ly, last_y, row;
  logic empty, top, bot, left, right;
  logic [ADDR_W-1:0] base, raddr, clr_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic [CW-1:0] wr_data, rdata;
  logic wr_en, hit, oor;
  logic [PW-1:0] prod_base, prod_rd;
  logic signed [ccrde_pkg::COORD_W-1:0] xa, xb, ya, yb;
  logic [CW-1:0] mem [0:DEPTH-1];

  assign eff_w = (width_in_use > W_CAP) ? W_CAP : width_in_use;
  assign eff_h = (height_in_use > H_CAP) ? H_CAP : height_in_use;
  assign ww_s  = $signed(XW'(eff_w));
  assign hh_s  = $signed(XW'(eff_h));

  always_ff @(posedge clk) begin
    if (rst) begin
      width_in_use  <= ccrde_pkg::WIDTH_RESET;
      height_in_use <= ccrde_pkg::HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        ccrde_pkg::REG_WIDTH:  width_in_use  <= cfg_data[WW-1:0];
        ccrde_pkg::REG_HEIGHT: height_in_use <= cfg_data[HW-1:0];
        default: ;
      endcase
    end
  end

  // corner sort
  assign xa = req_q.first_x;
  assign xb = req_q.second_x;
  assign ya = req_q.first_y;
  assign yb = req_q.second_y;

  // clip against the framebuffer, upper bounds exclusive
  assign lx_c = x0[XW-1] ? '0 : x0;
  assign ly_c = y0[XW-1] ? '0 : y0;
  assign hx_c = (x1 > ww_s) ? ww_s : x1;
  assign hy_c = (y1 > hh_s) ? hh_s : y1;

  assign prod_base = PW'(ly) * PW'(eff_w);
  assign prod_rd   = PW'(req_q.first_y[HW-1:0]) * PW'(eff_w);

  assign hit = req_q.filled
            || (top   && row == ly)
            || (bot   && row == last_y)
            || (left  && col == lx)
            || (right && col == last_x);

  assign stat.clear_last = (clr_addr == CLR_LAST);
  assign stat.empty      = empty;
  assign stat.walk_last  = (col == last_x) && (row == last_y);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = base + ADDR_W'(col);
    wr_data = {req_q.attr, req_q.glyph};
    case (cmd.op)
      ccrde_pkg::OP_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr;
        wr_data = '0;
      end
      ccrde_pkg::OP_STEP: wr_en = hit;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (cmd.op == ccrde_pkg::OP_RREAD) rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.op == ccrde_pkg::OP_CLEAR) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      ccrde_pkg::OP_LOAD: req_q <= req;
      ccrde_pkg::OP_SORT: begin
        if (xb < xa) begin
          x0 <= XW'(xb);
          x1 <= XW'(xa) + XW'(1);
        end else begin
          x0 <= XW'(xa);
          x1 <= XW'(xb) + XW'(1);
        end
        if (yb < ya) begin
          y0 <= XW'(yb);
          y1 <= XW'(ya) + XW'(1);
        end else begin
          y0 <= XW'(ya);
          y1 <= XW'(yb) + XW'(1);
        end
      end
      ccrde_pkg::OP_CLIP: begin
        empty  <= (lx_c >= hx_c) || (ly_c >= hy_c);
        lx     <= lx_c[WW-1:0];
        ly     <= ly_c[HW-1:0];
        last_x <= WW'(hx_c - XW'(1));
        last_y <= HW'(hy_c - XW'(1));
        top    <= !y0[XW-1];
        left   <= !x0[XW-1];
        bot    <= (y1 <= hh_s);
        right  <= (x1 <= ww_s);
      end
      ccrde_pkg::OP_BASE: begin
        base <= ADDR_W'(prod_base);
        col  <= lx;
        row  <= ly;
      end
      ccrde_pkg::OP_STEP: begin
        if (col == last_x) begin
          col  <= lx;
          row  <= row + 1'b1;
          base <= base + ADDR_W'(eff_w);
        end else begin
          col <= col + 1'b1;
        end
      end
      ccrde_pkg::OP_RADDR: begin
        oor <= req_q.first_x[ccrde_pkg::COORD_W-1]
            || req_q.first_y[ccrde_pkg::COORD_W-1]
            || (XW'(req_q.first_x) >= ww_s)
            || (XW'(req_q.first_y) >= hh_s);
        raddr <= ADDR_W'(prod_rd) + ADDR_W'(req_q.first_x[WW-1:0]);
      end
      default: ;
    endcase
  end

  always_comb begin
    rsp_next = '0;
    if (req_q.req_type == ccrde_pkg::REQ_READ) begin
      if (oor) begin
        rsp_next.status = ccrde_pkg::STATUS_OOR;
      end else begin
        rsp_next.read_glyph = rdata[ccrde_pkg::GLYPH_W-1:0];
        rsp_next.read_attr  = rdata[CW-1:ccrde_pkg::GLYPH_W];
        rsp_next.status     = ccrde_pkg::STATUS_DONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rsp_load) rsp <= rsp_next;
  end

endmodule

/* design/char_cell_rect_draw_engine.sv */
// Character-cell framebuffer with a clipped rectangle draw engine.
// Top level: joins ccrde_ctrl and ccrde_dp. Depends on ccrde_pkg.
//
// After reset the cell memory is cleared one cell per cycle, all MAX_WIDTH *
// MAX_HEIGHT cells (8192 by default); req_stall stays high until the clear
// is done, while configuration writes are taken. Each item is handled on its
// own. A read range-checks and forms the address, then reads the cell memory.
// A draw sorts and clips the corners, forms the row base, then walks every
// cell of the clipped rectangle, outlines included, since the single memory
// write port stores one cell per cycle; a draw that clips to nothing skips
// the walk. The result sits in an output register, so the next item is
// accepted while a finished result still waits on rsp_stall.
module char_cell_rect_draw_engine #(
  parameter int MAX_WIDTH  = ccrde_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = ccrde_pkg::DEF_MAX_HEIGHT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_stall,
  input  ccrde_pkg::req_t                   req,
  output logic                              rsp_valid,
  input  logic                              rsp_stall,
  output ccrde_pkg::rsp_t                   rsp,
  input  logic                              cfg_we,
  input  logic [ccrde_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ccrde_pkg::CFG_DATA_W-1:0]  cfg_data
);

  ccrde_pkg::cmd_t  cmd;
  ccrde_pkg::stat_t stat;

  ccrde_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_read  (req.req_type == ccrde_pkg::REQ_READ),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  ccrde_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .req       (req),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

/* bench/ccrde_cell_checker.sv */
// Checker for char_cell_rect_draw_engine: watches the request, result and
// register ports, keeps its own cell store and sizes, and compares results.
// Depends on ccrde_pkg.
module ccrde_cell_checker
  import ccrde_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  input  logic                  req_stall,
  input  req_t                  req,
  input  logic                  rsp_valid,
  input  logic                  rsp_stall,
  input  rsp_t                  rsp,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    pending,
  output int                    results_seen
);

  localparam int CELLS = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;

  logic [CELL_W-1:0] cells [CELLS];
  int                fb_w;
  int                fb_h;
  rsp_t              cell_rsp_q [$];

  function automatic void put(int x, int y, logic [CELL_W-1:0] c);
    int idx;
    idx = x + y * fb_w;
    if (idx >= 0 && idx < CELLS) cells[idx] = c;
  endfunction

  function automatic void flag(string what, int unsigned want, int unsigned got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: result %0d %s: expected %0h, got %0h", $time, results_seen, what,
               want, got);
  endfunction

  always @(posedge clk) begin : observe
    rsp_t              want;
    rsp_t              got;
    logic [CELL_W-1:0] c;
    int                x0, y0, x1, y1, lx, ly, hx, hy, t, i, j;
    if (rst) begin
      foreach (cells[k]) cells[k] = '0;
      fb_w = WIDTH_RESET;
      fb_h = HEIGHT_RESET;
      cell_rsp_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_WIDTH)
          fb_w = (cfg_data > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : cfg_data;
        else if (cfg_index == REG_HEIGHT)
          fb_h = (cfg_data[CFG_HEIGHT_W-1:0] > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT
                                                                 : cfg_data[CFG_HEIGHT_W-1:0];
      end

      if (rsp_valid && !rsp_stall) begin
        results_seen++;
        got = rsp;
        if (cell_rsp_q.size() == 0) begin
          flag("arrived with nothing outstanding", 0, got);
        end else begin
          want = cell_rsp_q.pop_front();
          if (got.read_glyph !== want.read_glyph)
            flag("read_glyph", want.read_glyph, got.read_glyph);
          if (got.read_attr !== want.read_attr)
            flag("read_attr", want.read_attr, got.read_attr);
          if (got.status !== want.status)
            flag("status", want.status, got.status);
        end
      end

      if (req_valid && !req_stall) begin
        want = '0;
        want.status = STATUS_DONE;
        x0 = $signed(req.first_x);
        y0 = $signed(req.first_y);
        if (req.req_type == REQ_READ) begin
          if (x0 >= 0 && x0 < fb_w && y0 >= 0 && y0 < fb_h) begin
            c = cells[x0 + y0 * fb_w];
            want.read_glyph = c[GLYPH_W-1:0];
            want.read_attr  = c[CELL_W-1:GLYPH_W];
          end else begin
            want.status = STATUS_OOR;
          end
        end else begin
          x1 = $signed(req.second_x);
          y1 = $signed(req.second_y);
          if (x1 < x0) begin t = x0; x0 = x1; x1 = t; end
          if (y1 < y0) begin t = y0; y0 = y1; y1 = t; end
          x1++;
          y1++;
          lx = (x0 > 0) ? x0 : 0;
          ly = (y0 > 0) ? y0 : 0;
          hx = (x1 < fb_w) ? x1 : fb_w;
          hy = (y1 < fb_h) ? y1 : fb_h;
          c  = {req.attr, req.glyph};
          if (lx < hx && ly < hy) begin
            if (req.filled) begin
              for (j = ly; j < hy; j++)
                for (i = lx; i < hx; i++) put(i, j, c);
            end else begin
              // only edges that survived clipping
              if (ly == y0) for (i = lx; i < hx; i++) put(i, ly, c);
              if (hy == y1) for (i = lx; i < hx; i++) put(i, hy - 1, c);
              if (lx == x0) for (j = ly; j < hy; j++) put(lx, j, c);
              if (hx == x1) for (j = ly; j < hy; j++) put(hx - 1, j, c);
            end
          end
        end
        cell_rsp_q.push_back(want);
      end
    end
    pending = cell_rsp_q.size();
  end

endmodule

/* bench/tb_char_cell_rect_draw_engine.sv */
// Testbench top for char_cell_rect_draw_engine: drives draw and read items,
// size register writes and result stalls; ccrde_cell_checker does the checks.
// Depends on ccrde_pkg, ccrde_cell_checker and the engine RTL.
module tb_char_cell_rect_draw_engine;
  import ccrde_pkg::*;

  localparam int IDLE_LIMIT = 50000;
  localparam int PER_PHASE  = 11;
  localparam int PHASES     = 7;
  localparam int SIZE_W [PHASES] = '{128, 1, 255, 0, 40, 37, 128};
  localparam int SIZE_H [PHASES] = '{64, 1, 127, 30, 0, 13, 64};

  logic                  clk;
  logic                  rst       = 1'b1;
  logic                  req_valid = 1'b0;
  logic                  req_stall;
  req_t                  req       = '0;
  logic                  rsp_valid;
  logic                  rsp_stall = 1'b0;
  rsp_t                  rsp;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  int mismatches;
  int pending;
  int results_seen;
  int idle_cycles = 0;
  int cur_w       = WIDTH_RESET;
  int cur_h       = HEIGHT_RESET;
  int draws_sent  = 0;
  int reads_sent  = 0;
  bit quiet       = 1'b0;

  char_cell_rect_draw_engine dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  ccrde_cell_checker u_cell_chk (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .req          (req),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .rsp          (rsp),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .pending      (pending),
    .results_seen (results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // cycles with no item moving on either channel
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout: nothing moved for %0d cycles", IDLE_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  // result-side stall bursts
  initial begin : stall_gen
    int n;
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 11);
        rsp_stall <= 1'b1;
        repeat (n) @(negedge clk);
        rsp_stall <= 1'b0;
      end
    end
  end

  function automatic req_t rect(int x0, int y0, int x1, int y1,
                                logic [GLYPH_W-1:0] g, logic [ATTR_W-1:0] a, logic f);
    req_t r;
    r.req_type = REQ_DRAW;
    r.first_x  = COORD_W'(x0);
    r.first_y  = COORD_W'(y0);
    r.second_x = COORD_W'(x1);
    r.second_y = COORD_W'(y1);
    r.glyph    = g;
    r.attr     = a;
    r.filled   = f;
    return r;
  endfunction

  function automatic req_t peek(int x, int y);
    req_t        r;
    logic [95:0] noise;
    noise = {$urandom(), $urandom(), $urandom()};
    r = noise[$bits(req_t)-1:0];
    r.req_type = REQ_READ;
    r.first_x  = COORD_W'(x);
    r.first_y  = COORD_W'(y);
    return r;
  endfunction

  function automatic req_t random_item();
    int x0, y0, x1, y1, t, pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      if (cur_w > 0 && cur_h > 0 && pick < 32)
        return peek($urandom_range(0, cur_w - 1), $urandom_range(0, cur_h - 1));
      if (pick < 37)
        return peek(int'($urandom_range(0, cur_w + 8)) - 4,
                    int'($urandom_range(0, cur_h + 8)) - 4);
      return peek($urandom(), $urandom());
    end
    if (pick < 80) begin
      // small rectangles around the visible area, corners in either order
      x0 = int'($urandom_range(0, cur_w + 6)) - 3;
      y0 = int'($urandom_range(0, cur_h + 6)) - 3;
      x1 = x0 + int'($urandom_range(0, 16)) - 6;
      y1 = y0 + int'($urandom_range(0, 10)) - 4;
    end else if (pick < 92) begin
      // large, straddling the borders
      x0 = int'($urandom_range(0, 40)) - 20;
      y0 = int'($urandom_range(0, 20)) - 10;
      x1 = cur_w - 20 + int'($urandom_range(0, 40));
      y1 = cur_h - 10 + int'($urandom_range(0, 20));
      if ($urandom_range(0, 1)) begin t = x0; x0 = x1; x1 = t; end
      if ($urandom_range(0, 1)) begin t = y0; y0 = y1; y1 = t; end
    end else begin
      x0 = $urandom();
      y0 = $urandom();
      x1 = $urandom();
      y1 = $urandom();
    end
    return rect(x0, y0, x1, y1, $urandom(), $urandom(), $urandom_range(0, 1));
  endfunction

  task automatic send(req_t r);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      @(negedge clk);
      req_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req_valid <= 1'b1;
    req       <= r;
    do @(posedge clk); while (req_stall);
    if (r.req_type == REQ_DRAW) draws_sent++;
    else reads_sent++;
  endtask

  task automatic settle();
    @(negedge clk);
    req_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (8) @(negedge clk);
  endtask

  task automatic resize(int w, int h);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_WIDTH;
    cfg_data  <= CFG_DATA_W'(w);
    @(negedge clk);
    cfg_index <= REG_HEIGHT;
    cfg_data  <= CFG_DATA_W'(h);
    @(negedge clk);
    cfg_we    <= 1'b0;
    cur_w = (w > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : w;
    cur_h = (h > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : h;
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // directed, at the reset size of 80 x 25
    send(peek(0, 0));
    send(peek(79, 24));
    send(peek(80, 0));
    send(peek(0, 25));
    send(peek(-1, -1));
    send(peek(-2048, 2047));
    send(peek(2047, -2048));
    send(rect(10, 8, 2, 3, 8'hFF, 16'hFFFF, 1'b1));
    send(peek(2, 3));
    send(peek(11, 8));
    send(rect(20, 5, 30, 12, 8'h41, 16'h8001, 1'b0));
    send(peek(25, 5));
    send(peek(25, 8));
    send(rect(6, 4, -5, -5, 8'h80, 16'h7FFE, 1'b0));
    send(peek(0, 4));
    send(peek(0, 0));
    send(rect(70, 20, 2047, 2047, 8'h5A, 16'hA5A5, 1'b0));
    send(peek(79, 20));
    send(peek(79, 24));
    send(rect(-2048, -2048, -1, -1, 8'h12, 16'h3456, 1'b1));
    send(rect(80, 0, 2047, 10, 8'h12, 16'h3456, 1'b1));
    send(rect(-2048, -2048, 2047, 2047, 8'h01, 16'h0002, 1'b0));
    send(rect(2047, 2047, -2048, -2048, 8'h33, 16'hCCCC, 1'b1));
    send(rect(5, 5, 5, 5, 8'h00, 16'h0000, 1'b0));
    send(peek(5, 5));
    settle();

    for (int p = 0; p < PHASES; p++) begin
      quiet = (p == PHASES - 1);
      resize(SIZE_W[p], SIZE_H[p]);
      repeat (PER_PHASE) send(random_item());
      settle();
    end

    $display("Sent %0d draws and %0d reads over %0d framebuffer sizes,", draws_sent,
             reads_sent, PHASES + 1);
    $display("%0d results compared, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0 && pending == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
